// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the core RTL; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define TBDP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("tbdp: property violated");

// Condition must never be seen at a clock edge outside reset.
`define TBDP_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("tbdp: forbidden condition seen");

`else

`define TBDP_ASSERT(lbl, clk, rst_n, prop)
`define TBDP_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== rtl/core/tbdp_pkg.sv =====
package tbdp_pkg;

	localparam int CMD_W    = 2;
	localparam int KIND_W   = 3;
	localparam int ADDR_W   = 32;
	localparam int COUNT_W  = 6;
	localparam int HFIELD_W = 8;
	localparam int BITS_W   = 32;
	localparam int STEP_W   = 5;
	localparam int APB_W    = 32;
	localparam int PADDR_W  = 3;

	typedef logic [1:0] ctr_t;

	localparam ctr_t CTR_MIN        = 2'd0;
	localparam ctr_t CTR_MAX        = 2'd3;
	localparam ctr_t CTR_WEAK_TAKEN = 2'd2;

	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
	localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_MULTI  = 2'd2;

	localparam logic [KIND_W-1:0] KIND_PERFECT   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_TAKEN     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_NOT_TAKEN = 3'd2;
	localparam logic [KIND_W-1:0] KIND_BIMODAL   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_TWO_LEVEL = 3'd4;
	localparam logic [KIND_W-1:0] KIND_COMBINED  = 3'd5;

	// Register select is the word address bit of paddr.
	localparam logic REG_KIND = 1'b0;

	function automatic ctr_t sat_count(ctr_t c, logic up);
		ctr_t r;
		if (up) begin
			r = (c == CTR_MAX) ? c : c + 2'd1;
		end else begin
			r = (c == CTR_MIN) ? c : c - 2'd1;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/tbdp_ram.sv =====
module tbdp_ram #(
	parameter int     WIDTH = 2,
	parameter longint DEPTH = 2
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/tournament_branch_direction_predictor_core.sv =====
// Lookup: start taken, then S_HIST and S_LRES; done is registered as the FSM returns to
// idle, where a next start can be taken. Update: via S_UPD, no result. Multiple lookup:
// S_HIST, then S_MSTEP walks the chain to done, one pattern table read per chained
// prediction on its single read port. Reset: predictor_kind to two-level; then a clearing
// pass over the deepest table (pattern, 262144 entries by default) sets every table, busy meanwhile.
// The result strobe done lasts one cycle; the receiver cannot stall it.
`include "assert_macros.svh"

module tournament_branch_direction_predictor_core #(
	parameter int BIMODAL_ENTRIES = 1024,
	parameter int CHOICE_ENTRIES  = 1024,
	parameter int HISTORY_ENTRIES = 1,
	parameter int PATTERN_COLUMNS = 1024,
	parameter int HISTORY_BITS    = 8,
	parameter int MAX_CHAIN       = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            start,
	output logic                            busy,
	input  logic [tbdp_pkg::CMD_W-1:0]      command,
	input  logic [tbdp_pkg::ADDR_W-1:0]     branch_address,
	input  logic                            is_unconditional,
	input  logic                            is_internal_branch,
	input  logic                            actually_taken,
	input  logic [tbdp_pkg::COUNT_W-1:0]    prediction_count,
	input  logic [tbdp_pkg::HFIELD_W-1:0]   lookup_history,
	input  logic                            lookup_bimodal_guess,
	input  logic                            lookup_two_level_guess,
	input  logic                            lookup_choice_guess,

	output logic                            done,
	output logic [tbdp_pkg::BITS_W-1:0]     predicted_bits,
	output logic                            bimodal_guess,
	output logic                            two_level_guess,
	output logic                            choice_guess,
	output logic [tbdp_pkg::HFIELD_W-1:0]   history_used,

	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tbdp_pkg::PADDR_W-1:0]    paddr,
	input  logic [tbdp_pkg::APB_W-1:0]      pwdata,
	output logic [tbdp_pkg::APB_W-1:0]      prdata,
	output logic                            pready
);

	import tbdp_pkg::*;

	localparam longint PAT_DEPTH = longint'(PATTERN_COLUMNS) << HISTORY_BITS;
	localparam longint CLR_A     = (BIMODAL_ENTRIES > CHOICE_ENTRIES) ?
		longint'(BIMODAL_ENTRIES) : longint'(CHOICE_ENTRIES);
	localparam longint CLR_B     = (PAT_DEPTH > longint'(HISTORY_ENTRIES)) ?
		PAT_DEPTH : longint'(HISTORY_ENTRIES);
	localparam longint CLR_DEPTH = (CLR_A > CLR_B) ? CLR_A : CLR_B;

	localparam int BIM_AW  = $clog2(BIMODAL_ENTRIES);
	localparam int CHO_AW  = $clog2(CHOICE_ENTRIES);
	localparam int HIST_AW = (HISTORY_ENTRIES > 1) ? $clog2(HISTORY_ENTRIES) : 1;
	localparam int COL_W   = (PATTERN_COLUMNS > 1) ? $clog2(PATTERN_COLUMNS) : 1;
	localparam int PAT_AW  = $clog2(PAT_DEPTH);
	localparam int CLR_W   = $clog2(CLR_DEPTH);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HIST  = 3'd2;
	localparam logic [2:0] S_LRES  = 3'd3;
	localparam logic [2:0] S_UPD   = 3'd4;
	localparam logic [2:0] S_MSTEP = 3'd5;

	typedef logic [HISTORY_BITS-1:0] hist_t;

	logic [2:0]        state_q;
	logic [CLR_W-1:0]  clr_q;
	logic [STEP_W-1:0] step_q;
	logic              done_q;
	logic [KIND_W-1:0] kind_q;

	// captured transaction
	logic [CMD_W-1:0]  cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic              uncond_q;
	logic              internal_q;
	logic              taken_q;
	hist_t             lk_hist_q;
	logic              lk_bim_q;
	logic              lk_two_q;
	logic              lk_cho_q;
	logic [STEP_W-1:0] last_q;
	hist_t             row_q;
	hist_t             bhr_q;
	logic [BITS_W-1:0] bits_q;

	logic [BITS_W-1:0]   pred_bits_q;
	logic                bim_guess_q;
	logic                two_guess_q;
	logic                cho_guess_q;
	logic [HFIELD_W-1:0] hist_used_q;

	logic [ADDR_W-1:0]  addr_sel;
	logic [BIM_AW-1:0]  bim_idx;
	logic [CHO_AW-1:0]  cho_idx;
	logic [HIST_AW-1:0] hist_idx;
	logic [COL_W-1:0]   col;
	hist_t              slot_row;
	logic [PAT_AW-1:0]  pat_idx;

	ctr_t  bim_rdata, cho_rdata, pat_rdata;
	hist_t hist_rdata;

	logic              accept;
	logic              clearing;
	logic              clr_last;
	logic              upd;
	logic              train_bim, train_two, train_cho;
	logic              mlast;
	logic              step_p;
	hist_t             bhr_next;
	logic [BITS_W-1:0] bits_next;
	logic              lk_pred;
	logic [STEP_W-1:0] last_in;

	logic bim_we, cho_we, hist_we, pat_we;
	logic [BIM_AW-1:0]  bim_waddr;
	logic [CHO_AW-1:0]  cho_waddr;
	logic [HIST_AW-1:0] hist_waddr;
	logic [PAT_AW-1:0]  pat_waddr;
	ctr_t  bim_wdata, cho_wdata, pat_wdata;
	hist_t hist_wdata;
	logic  tbl_re, pat_re;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign clearing = (state_q == S_CLEAR);
	assign clr_last = (clr_q == CLR_W'(CLR_DEPTH - 1));

	// Table indices come from the live port while idle, else from the capture.
	assign addr_sel = (state_q == S_IDLE) ? branch_address : addr_q;
	assign bim_idx  = BIM_AW'(addr_sel & ADDR_W'(BIMODAL_ENTRIES - 1));
	assign cho_idx  = CHO_AW'(addr_sel & ADDR_W'(CHOICE_ENTRIES - 1));
	assign hist_idx = HIST_AW'(addr_sel & ADDR_W'(HISTORY_ENTRIES - 1));
	assign col      = COL_W'(addr_sel & ADDR_W'(PATTERN_COLUMNS - 1));

	// Chained walk: shift the predicted direction into the history.
	assign step_p   = pat_rdata[1];
	assign bhr_next = hist_t'({bhr_q, step_p});
	assign mlast    = (step_q == last_q);

	always_comb begin
		bits_next         = bits_q;
		bits_next[step_q] = step_p;
	end

	// Shared pattern slot unit: row * columns + column.
	always_comb begin
		unique case (state_q)
			S_IDLE:  slot_row = hist_t'(lookup_history);
			S_HIST:  slot_row = hist_rdata;
			S_MSTEP: slot_row = bhr_next;
			default: slot_row = lk_hist_q;
		endcase
	end

	assign pat_idx = PAT_AW'(slot_row) * PAT_AW'(PATTERN_COLUMNS) + PAT_AW'(col);

	always_comb begin
		if (prediction_count == '0) begin
			last_in = '0;
		end else if (prediction_count > COUNT_W'(MAX_CHAIN)) begin
			last_in = STEP_W'(MAX_CHAIN - 1);
		end else begin
			last_in = STEP_W'(prediction_count - COUNT_W'(1));
		end
	end

	always_comb begin
		priority if (uncond_q || internal_q) begin
			lk_pred = 1'b1;
		end else begin
			unique case (kind_q)
				KIND_PERFECT:   lk_pred = taken_q;
				KIND_TAKEN:     lk_pred = 1'b1;
				KIND_BIMODAL:   lk_pred = bim_rdata[1];
				KIND_TWO_LEVEL: lk_pred = pat_rdata[1];
				KIND_COMBINED:  lk_pred = cho_rdata[1] ? pat_rdata[1] : bim_rdata[1];
				default:        lk_pred = 1'b0;
			endcase
		end
	end

	// Training: only the component that served the lookup, and the chooser when guesses differed.
	assign upd       = (state_q == S_UPD) && !uncond_q;
	assign train_bim = upd && ((kind_q == KIND_BIMODAL) ||
		((kind_q == KIND_COMBINED) && !lk_cho_q));
	assign train_two = upd && ((kind_q == KIND_TWO_LEVEL) ||
		((kind_q == KIND_COMBINED) && lk_cho_q));
	assign train_cho = upd && (kind_q == KIND_COMBINED) && (lk_bim_q != lk_two_q);

	assign tbl_re = accept;
	assign pat_re = accept || (state_q == S_HIST) || ((state_q == S_MSTEP) && !mlast);

	assign bim_we     = clearing ? ({1'b0, clr_q} < (CLR_W + 1)'(BIMODAL_ENTRIES)) : train_bim;
	assign bim_waddr  = clearing ? clr_q[BIM_AW-1:0] : bim_idx;
	assign bim_wdata  = clearing ? CTR_WEAK_TAKEN : sat_count(bim_rdata, taken_q);

	assign cho_we     = clearing ? ({1'b0, clr_q} < (CLR_W + 1)'(CHOICE_ENTRIES)) : train_cho;
	assign cho_waddr  = clearing ? clr_q[CHO_AW-1:0] : cho_idx;
	assign cho_wdata  = clearing ? CTR_WEAK_TAKEN : sat_count(cho_rdata, lk_bim_q != taken_q);

	assign hist_we    = clearing ? ({1'b0, clr_q} < (CLR_W + 1)'(HISTORY_ENTRIES)) : train_two;
	assign hist_waddr = clearing ? clr_q[HIST_AW-1:0] : hist_idx;
	assign hist_wdata = clearing ? '0 : hist_t'({hist_rdata, taken_q});

	assign pat_we     = clearing ? ({1'b0, clr_q} < (CLR_W + 1)'(PAT_DEPTH)) : train_two;
	assign pat_waddr  = clearing ? clr_q[PAT_AW-1:0] : pat_idx;
	assign pat_wdata  = clearing ? CTR_WEAK_TAKEN : sat_count(pat_rdata, taken_q);

	tbdp_ram #(.WIDTH(2), .DEPTH(longint'(BIMODAL_ENTRIES))) u_bim_ram (
		.clk(clk), .we(bim_we), .waddr(bim_waddr), .wdata(bim_wdata),
		.re(tbl_re), .raddr(bim_idx), .rdata(bim_rdata)
	);

	tbdp_ram #(.WIDTH(2), .DEPTH(longint'(CHOICE_ENTRIES))) u_cho_ram (
		.clk(clk), .we(cho_we), .waddr(cho_waddr), .wdata(cho_wdata),
		.re(tbl_re), .raddr(cho_idx), .rdata(cho_rdata)
	);

	tbdp_ram #(.WIDTH(HISTORY_BITS), .DEPTH(longint'(HISTORY_ENTRIES))) u_hist_ram (
		.clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
		.re(tbl_re), .raddr(hist_idx), .rdata(hist_rdata)
	);

	tbdp_ram #(.WIDTH(2), .DEPTH(PAT_DEPTH)) u_pat_ram (
		.clk(clk), .we(pat_we), .waddr(pat_waddr), .wdata(pat_wdata),
		.re(pat_re), .raddr(pat_idx), .rdata(pat_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					if (clr_last) begin
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (start) begin
						unique case (command)
							CMD_LOOKUP, CMD_MULTI: state_q <= S_HIST;
							CMD_UPDATE:            state_q <= S_UPD;
							default:               state_q <= S_IDLE;
						endcase
					end
				end
				S_HIST: begin
					step_q  <= '0;
					state_q <= (cmd_q == CMD_MULTI) ? S_MSTEP : S_LRES;
				end
				S_LRES: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_UPD: begin
					state_q <= S_IDLE;
				end
				S_MSTEP: begin
					if (mlast) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= command;
			addr_q     <= branch_address;
			uncond_q   <= is_unconditional;
			internal_q <= is_internal_branch;
			taken_q    <= actually_taken;
			lk_hist_q  <= hist_t'(lookup_history);
			lk_bim_q   <= lookup_bimodal_guess;
			lk_two_q   <= lookup_two_level_guess;
			lk_cho_q   <= lookup_choice_guess;
			last_q     <= last_in;
		end
		if (state_q == S_HIST) begin
			row_q  <= hist_rdata;
			bhr_q  <= hist_rdata;
			bits_q <= '0;
		end
		if (state_q == S_MSTEP) begin
			bhr_q  <= bhr_next;
			bits_q <= bits_next;
		end
		if (state_q == S_LRES) begin
			pred_bits_q <= BITS_W'(lk_pred);
			bim_guess_q <= bim_rdata[1];
			two_guess_q <= pat_rdata[1];
			cho_guess_q <= cho_rdata[1];
			hist_used_q <= HFIELD_W'(row_q);
		end
		if ((state_q == S_MSTEP) && mlast) begin
			pred_bits_q <= bits_next;
			bim_guess_q <= 1'b0;
			two_guess_q <= 1'b0;
			cho_guess_q <= 1'b0;
			hist_used_q <= HFIELD_W'(row_q);
		end
	end

	assign done            = done_q;
	assign predicted_bits  = pred_bits_q;
	assign bimodal_guess   = bim_guess_q;
	assign two_level_guess = two_guess_q;
	assign choice_guess    = cho_guess_q;
	assign history_used    = hist_used_q;

	// Configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_TWO_LEVEL;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_KIND)) begin
			kind_q <= pwdata[KIND_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_KIND) ? APB_W'(kind_q) : '0;

	`TBDP_ASSERT(a_done_src, clk, arst_n, done_q |-> ($past(state_q) == S_LRES || $past(state_q) == S_MSTEP))
	`TBDP_ASSERT(a_step_bound, clk, arst_n, (state_q == S_MSTEP) |-> (step_q <= last_q))
	`TBDP_NEVER(a_done_busy, clk, arst_n, done_q && busy)

endmodule

// ===== tb/testbench.sv =====
module testbench;
	import tbdp_pkg::*;

	localparam int BIM_N = 1024;
	localparam int CHO_N = 1024;
	localparam int HIST_W = 8;
	localparam int COL_W = 10;
	localparam int PAT_N = 1 << (HIST_W + COL_W);
	localparam int CHAIN_MAX = 32;
	localparam int SETTLE_CYCLES = CHAIN_MAX + 8;
	localparam int WATCHDOG_LIMIT = 800000;
	localparam int PHASES = 12;
	localparam int ITEMS_PER_PHASE = 115;
	localparam int SITES = 12;

	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
	localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
	localparam logic OFF = 1'b0;
	localparam logic ON = 1'b1;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [ADDR_W-1:0]   addr;
		logic                uncond;
		logic                internal;
		logic                taken;
		logic [COUNT_W-1:0]  count;
		logic [HFIELD_W-1:0] lk_hist;
		logic                lk_bim;
		logic                lk_two;
		logic                lk_cho;
	} branch_req_t;

	typedef struct packed {
		logic [BITS_W-1:0]   bits;
		logic                bim;
		logic                two;
		logic                cho;
		logic [HFIELD_W-1:0] hist;
	} branch_pred_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		branch_req_t       req;
		logic              typed;
		branch_pred_t      want;
	} script_row_t;

	localparam int SCRIPT_LEN = 29;
	localparam branch_pred_t NONE = '0;

	// Rows with typed results: fresh tables after reset, chain length extremes.
	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		'{KIND_TWO_LEVEL, '{CMD_LOOKUP, 32'h0, OFF, OFF, OFF, 6'd0, 8'h00, OFF, OFF, OFF},
			ON, '{32'h1, ON, ON, ON, 8'h00}},
		'{KIND_TWO_LEVEL, '{CMD_LOOKUP, 32'hFFFF_FFFF, OFF, OFF, ON, 6'd63, 8'hFF, ON, ON, ON},
			ON, '{32'h1, ON, ON, ON, 8'h00}},
		'{KIND_TWO_LEVEL, '{CMD_MULTI, 32'h0, OFF, OFF, OFF, 6'd0, 8'h00, OFF, OFF, OFF},
			ON, '{32'h1, OFF, OFF, OFF, 8'h00}},
		'{KIND_TWO_LEVEL, '{CMD_MULTI, 32'hFFFF_FFFF, ON, ON, ON, 6'd32, 8'hFF, ON, ON, ON},
			ON, '{32'hFFFF_FFFF, OFF, OFF, OFF, 8'h00}},
		'{KIND_TWO_LEVEL, '{CMD_MULTI, 32'h155, OFF, OFF, OFF, 6'd63, 8'h00, OFF, OFF, OFF},
			ON, '{32'hFFFF_FFFF, OFF, OFF, OFF, 8'h00}},
		'{KIND_TWO_LEVEL, '{CMD_SPARE, 32'hFFFF_FFFF, ON, ON, ON, 6'd63, 8'hFF, ON, ON, ON},
			OFF, NONE},
		'{KIND_TWO_LEVEL, '{CMD_UPDATE, 32'h0, OFF, OFF, OFF, 6'd1, 8'h00, ON, ON, ON},
			OFF, NONE},
		'{KIND_TWO_LEVEL, '{CMD_UPDATE, 32'h0, OFF, OFF, OFF, 6'd1, 8'h00, ON, ON, ON},
			OFF, NONE},
		'{KIND_TWO_LEVEL, '{CMD_LOOKUP, 32'h0, OFF, OFF, OFF, 6'd1, 8'h00, OFF, OFF, OFF},
			OFF, NONE},
		'{KIND_TWO_LEVEL, '{CMD_MULTI, 32'h0, OFF, OFF, OFF, 6'd5, 8'h00, OFF, OFF, OFF},
			OFF, NONE},
		'{KIND_TWO_LEVEL, '{CMD_UPDATE, 32'h3FF, OFF, ON, ON, 6'd1, 8'hFF, OFF, OFF, OFF},
			OFF, NONE},
		'{KIND_TWO_LEVEL, '{CMD_UPDATE, 32'h3FF, ON, OFF, OFF, 6'd1, 8'h00, OFF, OFF, OFF},
			OFF, NONE},
		'{KIND_TWO_LEVEL, '{CMD_LOOKUP, 32'h0, ON, OFF, OFF, 6'd1, 8'h00, OFF, OFF, OFF},
			OFF, NONE},
		'{KIND_TWO_LEVEL, '{CMD_LOOKUP, 32'h3FF, OFF, ON, OFF, 6'd1, 8'h00, OFF, OFF, OFF},
			OFF, NONE},
		'{KIND_PERFECT, '{CMD_LOOKUP, 32'h0, OFF, OFF, ON, 6'd1, 8'h00, OFF, OFF, OFF},
			OFF, NONE},
		'{KIND_PERFECT, '{CMD_LOOKUP, 32'h0, OFF, OFF, OFF, 6'd1, 8'h00, OFF, OFF, OFF},
			OFF, NONE},
		'{KIND_PERFECT, '{CMD_UPDATE, 32'h0, OFF, OFF, ON, 6'd1, 8'h00, ON, OFF, ON},
			OFF, NONE},
		'{KIND_TAKEN, '{CMD_LOOKUP, 32'h0, OFF, OFF, OFF, 6'd1, 8'h00, OFF, OFF, OFF},
			OFF, NONE},
		'{KIND_NOT_TAKEN, '{CMD_LOOKUP, 32'h0, OFF, OFF, ON, 6'd1, 8'h00, OFF, OFF, OFF},
			OFF, NONE},
		'{KIND_NOT_TAKEN, '{CMD_LOOKUP, 32'h0, ON, OFF, OFF, 6'd1, 8'h00, OFF, OFF, OFF},
			OFF, NONE},
		'{KIND_BIMODAL, '{CMD_UPDATE, 32'h5, OFF, ON, OFF, 6'd1, 8'h00, OFF, OFF, OFF},
			OFF, NONE},
		'{KIND_BIMODAL, '{CMD_UPDATE, 32'h5, ON, OFF, OFF, 6'd1, 8'h00, OFF, OFF, OFF},
			OFF, NONE},
		'{KIND_BIMODAL, '{CMD_LOOKUP, 32'h5, OFF, OFF, OFF, 6'd1, 8'h00, OFF, OFF, OFF},
			OFF, NONE},
		'{KIND_COMBINED, '{CMD_UPDATE, 32'h7, OFF, OFF, OFF, 6'd1, 8'h00, ON, OFF, OFF},
			OFF, NONE},
		'{KIND_COMBINED, '{CMD_UPDATE, 32'h7, OFF, OFF, ON, 6'd1, 8'h80, OFF, ON, ON},
			OFF, NONE},
		'{KIND_COMBINED, '{CMD_LOOKUP, 32'h7, OFF, OFF, OFF, 6'd1, 8'h00, OFF, OFF, OFF},
			OFF, NONE},
		'{KIND_SPARE_LO, '{CMD_LOOKUP, 32'h7, OFF, OFF, ON, 6'd1, 8'h00, OFF, OFF, OFF},
			OFF, NONE},
		'{KIND_SPARE_HI, '{CMD_UPDATE, 32'h7, OFF, OFF, ON, 6'd1, 8'h00, ON, OFF, ON},
			OFF, NONE},
		'{KIND_SPARE_HI, '{CMD_LOOKUP, 32'h0, OFF, OFF, ON, 6'd1, 8'h00, OFF, OFF, OFF},
			OFF, NONE}
	};

	localparam logic [KIND_W-1:0] PHASE_KINDS [PHASES] = '{
		KIND_BIMODAL, KIND_COMBINED, KIND_PERFECT, KIND_SPARE_HI, KIND_TWO_LEVEL, KIND_TAKEN,
		KIND_COMBINED, KIND_NOT_TAKEN, KIND_SPARE_LO, KIND_BIMODAL, KIND_COMBINED,
		KIND_TWO_LEVEL
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [CMD_W-1:0] command = '0;
	logic [ADDR_W-1:0] branch_address = '0;
	logic is_unconditional = 1'b0;
	logic is_internal_branch = 1'b0;
	logic actually_taken = 1'b0;
	logic [COUNT_W-1:0] prediction_count = '0;
	logic [HFIELD_W-1:0] lookup_history = '0;
	logic lookup_bimodal_guess = 1'b0;
	logic lookup_two_level_guess = 1'b0;
	logic lookup_choice_guess = 1'b0;
	logic done;
	logic [BITS_W-1:0] predicted_bits;
	logic bimodal_guess;
	logic two_level_guess;
	logic choice_guess;
	logic [HFIELD_W-1:0] history_used;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [APB_W-1:0] pwdata = '0;
	logic [APB_W-1:0] prdata;
	logic pready;

	// Marks a directed row whose result is typed into the table.
	logic typed_valid = 1'b0;
	branch_pred_t typed_want = '0;

	tournament_branch_direction_predictor_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.branch_address(branch_address),
		.is_unconditional(is_unconditional),
		.is_internal_branch(is_internal_branch),
		.actually_taken(actually_taken),
		.prediction_count(prediction_count),
		.lookup_history(lookup_history),
		.lookup_bimodal_guess(lookup_bimodal_guess),
		.lookup_two_level_guess(lookup_two_level_guess),
		.lookup_choice_guess(lookup_choice_guess),
		.done(done),
		.predicted_bits(predicted_bits),
		.bimodal_guess(bimodal_guess),
		.two_level_guess(two_level_guess),
		.choice_guess(choice_guess),
		.history_used(history_used),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Shadow of the predictor tables and the mode register.
	ctr_t bim_ctr [BIM_N];
	ctr_t cho_ctr [CHO_N];
	ctr_t pat_ctr [PAT_N];
	logic [HIST_W-1:0] global_hist;
	logic [KIND_W-1:0] model_kind;

	branch_pred_t pending_predictions [$];
	branch_pred_t last_lookup;
	int mismatches = 0;
	int idle_cycles = 0;

	function automatic ctr_t step_ctr(input ctr_t c, input logic up);
		if (up) begin
			return (c == CTR_MAX) ? c : c + 2'd1;
		end
		return (c == CTR_MIN) ? c : c - 2'd1;
	endfunction

	// Work out the result of one transaction and train the shadow tables.
	function automatic bit predict_direction(input branch_req_t r, output branch_pred_t p);
		logic [COL_W-1:0] col;
		logic [HIST_W-1:0] row;
		logic [HIST_W-1:0] bhr;
		logic [HIST_W+COL_W-1:0] slot;
		logic pred;
		logic bim;
		logic two;
		logic cho;
		logic dir;
		logic [KIND_W-1:0] k;
		int n;
		int i;
		col = r.addr[COL_W-1:0];
		row = global_hist;
		k = model_kind;
		p = '0;
		case (r.cmd)
			CMD_LOOKUP: begin
				bim = bim_ctr[col][1];
				two = pat_ctr[{row, col}][1];
				cho = cho_ctr[col][1];
				case (k)
					KIND_PERFECT: pred = r.taken;
					KIND_TAKEN: pred = 1'b1;
					KIND_BIMODAL: pred = bim;
					KIND_TWO_LEVEL: pred = two;
					KIND_COMBINED: pred = cho ? two : bim;
					default: pred = 1'b0;
				endcase
				if (r.uncond || r.internal) pred = 1'b1;
				p.bits[0] = pred;
				p.bim = bim;
				p.two = two;
				p.cho = cho;
				p.hist = row;
				return 1'b1;
			end
			CMD_UPDATE: begin
				if (r.uncond || k == KIND_PERFECT || k > KIND_COMBINED) return 1'b0;
				if (k == KIND_BIMODAL || (k == KIND_COMBINED && !r.lk_cho)) begin
					bim_ctr[col] = step_ctr(bim_ctr[col], r.taken);
				end
				if (k == KIND_TWO_LEVEL || (k == KIND_COMBINED && r.lk_cho)) begin
					slot = {r.lk_hist, col};
					global_hist = {global_hist[HIST_W-2:0], r.taken};
					pat_ctr[slot] = step_ctr(pat_ctr[slot], r.taken);
				end
				if (k == KIND_COMBINED && r.lk_bim != r.lk_two) begin
					cho_ctr[col] = step_ctr(cho_ctr[col], r.lk_bim != r.taken);
				end
				return 1'b0;
			end
			CMD_MULTI: begin
				n = int'(r.count);
				if (n == 0) n = 1;
				if (n > CHAIN_MAX) n = CHAIN_MAX;
				bhr = row;
				dir = pat_ctr[{bhr, col}][1];
				p.bits[0] = dir;
				for (i = 1; i < n; i++) begin
					bhr = {bhr[HIST_W-2:0], dir};
					dir = pat_ctr[{bhr, col}][1];
					p.bits[i] = dir;
				end
				p.hist = row;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	always @(posedge clk) begin
		branch_pred_t want;
		branch_pred_t got;
		branch_pred_t calc;
		branch_req_t req;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == '0) begin
				model_kind = pwdata[KIND_W-1:0];
				moved = 1'b1;
			end
			if (done) begin
				moved = 1'b1;
				got = '{predicted_bits, bimodal_guess, two_level_guess, choice_guess,
					history_used};
				if (pending_predictions.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, got bits=%h bim=%b two=%b cho=%b hist=%h",
						$time, got.bits, got.bim, got.two, got.cho, got.hist);
				end else begin
					want = pending_predictions.pop_front();
					if (got !== want) begin
						mismatches++;
						$display("%0t: result mismatch, expected bits=%h bim=%b two=%b cho=%b hist=%h",
							$time, want.bits, want.bim, want.two, want.cho, want.hist);
						$display("%0t:                    actual bits=%h bim=%b two=%b cho=%b hist=%h",
							$time, got.bits, got.bim, got.two, got.cho, got.hist);
					end
				end
			end
			if (start && !busy) begin
				moved = 1'b1;
				req = '{command, branch_address, is_unconditional, is_internal_branch,
					actually_taken, prediction_count, lookup_history, lookup_bimodal_guess,
					lookup_two_level_guess, lookup_choice_guess};
				if (predict_direction(req, calc)) begin
					pending_predictions.push_back(typed_valid ? typed_want : calc);
					if (req.cmd == CMD_LOOKUP) last_lookup = calc;
				end
			end
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	logic [KIND_W-1:0] cur_kind = KIND_TWO_LEVEL;
	int burst_left = 0;
	branch_req_t backlog [$];
	logic [ADDR_W-1:0] site_addr [SITES];
	int site_bias [SITES];

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic issue(input branch_req_t r, input logic typed, input branch_pred_t want);
		@(posedge clk);
		start <= 1'b1;
		command <= r.cmd;
		branch_address <= r.addr;
		is_unconditional <= r.uncond;
		is_internal_branch <= r.internal;
		actually_taken <= r.taken;
		prediction_count <= r.count;
		lookup_history <= r.lk_hist;
		lookup_bimodal_guess <= r.lk_bim;
		lookup_two_level_guess <= r.lk_two;
		lookup_choice_guess <= r.lk_cho;
		typed_valid <= typed;
		typed_want <= want;
		do @(negedge clk); while (busy);
		@(posedge clk);
		start <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		while (pending_predictions.size() != 0) @(negedge clk);
	endtask

	task automatic write_kind(input logic [KIND_W-1:0] k);
		logic [APB_W-1:0] v;
		v = ($urandom_range(0, 2) == 0) ? $urandom() : '0;
		v[KIND_W-1:0] = k;
		drain();
		// Let a trailing update or chain finish before touching the mode.
		repeat (SETTLE_CYCLES) @(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= '0;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		cur_kind = k;
	endtask

	task automatic pace();
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end else begin
			burst_left--;
		end
	endtask

	function automatic branch_req_t noise_req();
		branch_req_t r;
		r.cmd = 2'($urandom());
		r.addr = $urandom();
		r.uncond = 1'($urandom());
		r.internal = 1'($urandom());
		r.taken = 1'($urandom());
		r.count = 6'($urandom());
		r.lk_hist = 8'($urandom());
		r.lk_bim = 1'($urandom());
		r.lk_two = 1'($urandom());
		r.lk_cho = 1'($urandom());
		return r;
	endfunction

	initial begin
		branch_req_t r;
		branch_req_t u;
		int i;
		int phase;
		int items;
		int pick;
		int site;
		for (i = 0; i < BIM_N; i++) bim_ctr[i] = CTR_WEAK_TAKEN;
		for (i = 0; i < CHO_N; i++) cho_ctr[i] = CTR_WEAK_TAKEN;
		for (i = 0; i < PAT_N; i++) pat_ctr[i] = CTR_WEAK_TAKEN;
		global_hist = '0;
		model_kind = KIND_TWO_LEVEL;
		for (i = 0; i < SITES; i++) begin
			site_addr[i] = $urandom();
			site_bias[i] = 25 * $urandom_range(0, 4);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (i = 0; i < SCRIPT_LEN; i++) begin
			if (SCRIPT[i].kind != cur_kind) write_kind(SCRIPT[i].kind);
			issue(SCRIPT[i].req, SCRIPT[i].typed, SCRIPT[i].want);
			repeat ($urandom_range(0, 3)) @(negedge clk);
		end

		for (phase = 0; phase < PHASES; phase++) begin
			write_kind(PHASE_KINDS[phase]);
			items = 0;
			while (items < ITEMS_PER_PHASE) begin
				pick = $urandom_range(0, 99);
				r = noise_req();
				if (pick < 55 || (pick < 75 && backlog.size() == 0)) begin
					// Lookup of a known site, its training queued for later.
					site = $urandom_range(0, SITES - 1);
					r.cmd = CMD_LOOKUP;
					r.addr = site_addr[site];
					r.uncond = ($urandom_range(0, 9) == 0);
					r.internal = ($urandom_range(0, 9) == 0);
					r.taken = r.uncond || ($urandom_range(0, 99) < site_bias[site]);
					issue(r, 1'b0, '0);
					u = r;
					u.cmd = CMD_UPDATE;
					u.lk_hist = last_lookup.hist;
					u.lk_bim = last_lookup.bim;
					u.lk_two = last_lookup.two;
					u.lk_cho = last_lookup.cho;
					backlog.push_back(u);
				end else if (pick < 75) begin
					issue(backlog.pop_front(), 1'b0, '0);
				end else if (pick < 87) begin
					r.cmd = CMD_MULTI;
					if ($urandom_range(0, 1) == 0) r.addr = site_addr[$urandom_range(0, SITES - 1)];
					pick = $urandom_range(0, 9);
					r.count = (pick == 0) ? 6'd0 :
						(pick == 1) ? 6'($urandom_range(9, 63)) : 6'($urandom_range(1, 8));
					issue(r, 1'b0, '0);
				end else begin
					issue(r, 1'b0, '0);
				end
				if (r.cmd != CMD_SPARE) items++;
				pace();
				if ($urandom_range(0, 199) == 0) drain();
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending_predictions.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
